/* hdl/e2r_pkg.sv */
`default_nettype none

package e2r_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;

  // Binary angle widened to a full turn of 2^32, Q30 trig values
  localparam int TURN_W     = 32;
  localparam int TURN_SHIFT = TURN_W - ANGLE_BITS;
  localparam int Q30_FRAC   = 30;
  localparam int Q30_W      = 32;
  localparam int HORNER_W   = 31;
  localparam int PROD_W     = 2 * HORNER_W;

  localparam logic [TURN_W-1:0]   COS_OFFSET = TURN_W'(64'd1 << Q30_FRAC);
  localparam logic [HORNER_W-1:0] Q30_ONE    = HORNER_W'(64'd1 << Q30_FRAC);
  localparam logic [PROD_W:0]     Q30_HALF   = (PROD_W + 1)'(64'd1 << (Q30_FRAC - 1));

  // Pipeline: input prep, square, Horner cells, final product, then matrix
  localparam int HORNER_CELLS = 5;
  localparam int LANE_STAGES  = HORNER_CELLS + 3;
  localparam int MAT_STAGES   = 4;
  localparam int NUM_STAGES   = LANE_STAGES + MAT_STAGES;

  // Odd-power coefficients of the quarter-wave sine, C1 first
  localparam logic [HORNER_W-1:0] POLY_COEF [HORNER_CELLS+1] = '{
    31'd1686629713, 31'd693598669, 31'd85569306,
    31'd5026995, 31'd172272, 31'd3864
  };

  typedef logic signed [Q30_W-1:0] q30_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] r00;
    logic signed [ENTRY_BITS-1:0] r01;
    logic signed [ENTRY_BITS-1:0] r02;
    logic signed [ENTRY_BITS-1:0] r10;
    logic signed [ENTRY_BITS-1:0] r11;
    logic signed [ENTRY_BITS-1:0] r12;
    logic signed [ENTRY_BITS-1:0] r20;
    logic signed [ENTRY_BITS-1:0] r21;
    logic signed [ENTRY_BITS-1:0] r22;
  } matrix_t;

  // Data one Horner cell hands to the next
  typedef struct packed {
    logic [HORNER_W-1:0] p;
    logic [HORNER_W-1:0] u;
    logic [HORNER_W-1:0] t;
    logic                neg;
  } horner_t;

  typedef struct packed {
    q30_t sp;
    q30_t cp;
    q30_t sy;
    q30_t cy;
    q30_t sr;
    q30_t cr;
  } trig_t;

  // Non-negative product rescaled from Q60 to Q30, round half up
  function automatic logic [HORNER_W:0] rnd_q30_u(input logic [PROD_W-1:0] prod);
    logic [PROD_W:0] sum;
    sum = {1'b0, prod} + Q30_HALF;
    return sum[PROD_W-1:Q30_FRAC];
  endfunction

endpackage

`default_nettype wire

/* hdl/e2r_angle_if.sv */
`default_nettype none

interface e2r_angle_if import e2r_pkg::*; ();
  logic    valid;
  logic    ready;
  angles_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

`default_nettype wire

/* hdl/e2r_matrix_if.sv */
`default_nettype none

interface e2r_matrix_if import e2r_pkg::*; ();
  logic    valid;
  logic    ready;
  matrix_t rsp;

  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface

`default_nettype wire

/* hdl/e2r_horner_cell.sv */
`default_nettype none

module e2r_horner_cell import e2r_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [HORNER_W-1:0] coef_i,
  input  horner_t             stage_i,
  output horner_t             stage_o
);

  logic [PROD_W-1:0]   prod;
  logic [HORNER_W:0]   term;
  horner_t             stage_d, stage_q;

  // p <- C - rnd(p * u); stays non-negative over the quarter wave
  always_comb begin
    prod      = PROD_W'(stage_i.p) * PROD_W'(stage_i.u);
    term      = rnd_q30_u(prod);
    stage_d   = stage_i;
    stage_d.p = HORNER_W'({1'b0, coef_i} - term);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

/* hdl/e2r_sine_lane.sv */
`default_nettype none

module e2r_sine_lane import e2r_pkg::*; (
  input  logic                   clk_i,
  input  logic [LANE_STAGES-1:0] en_i,
  input  logic [TURN_W-1:0]      turn_i,
  output q30_t                   sine_o
);

  localparam int CELL_BASE = 2;

  logic [1:0]          quad;
  logic [Q30_FRAC-1:0] frac;
  horner_t             s1_d, s1_q, s2_d;
  horner_t             chain [HORNER_CELLS+1];
  logic [PROD_W-1:0]   sq_prod, fin_prod;
  logic [HORNER_W:0]   mag;
  q30_t                sine_d, sine_q;

  // Fold the turn into one quadrant; odd quadrants mirror the fraction
  always_comb begin
    quad     = turn_i[TURN_W-1 -: 2];
    frac     = turn_i[Q30_FRAC-1:0];
    s1_d.p   = '0;
    s1_d.u   = '0;
    s1_d.t   = quad[0] ? (Q30_ONE - HORNER_W'(frac)) : HORNER_W'(frac);
    s1_d.neg = quad[1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    sq_prod  = PROD_W'(s1_q.t) * PROD_W'(s1_q.t);
    s2_d     = s1_q;
    s2_d.u   = HORNER_W'(rnd_q30_u(sq_prod));
    s2_d.p   = POLY_COEF[HORNER_CELLS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      chain[0] <= s2_d;
    end
  end

  for (genvar i = 0; i < HORNER_CELLS; i++) begin : g_cell
    e2r_horner_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en_i[CELL_BASE+i]),
      .coef_i  (POLY_COEF[HORNER_CELLS-1-i]),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  always_comb begin
    fin_prod = PROD_W'(chain[HORNER_CELLS].p) * PROD_W'(chain[HORNER_CELLS].t);
    mag      = rnd_q30_u(fin_prod);
    sine_d   = chain[HORNER_CELLS].neg ? -Q30_W'(signed'(mag)) : Q30_W'(signed'(mag));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LANE_STAGES-1]) begin
      sine_q <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

`default_nettype wire

/* hdl/e2r_matrix.sv */
`default_nettype none

module e2r_matrix import e2r_pkg::*; (
  input  logic                  clk_i,
  input  logic [MAT_STAGES-1:0] en_i,
  input  trig_t                 trig_i,
  output matrix_t               matrix_o
);

  localparam int SUM_W     = Q30_W + 1;
  localparam int SCALE_W   = SUM_W + 2;
  localparam int OUT_SHIFT = (ENTRY_BITS >= 31) ? 0 : 31 - ENTRY_BITS;
  localparam logic signed [SCALE_W-1:0] ROUND_HALF =
    SCALE_W'((64'sd1 <<< OUT_SHIFT) >>> 1);
  localparam logic signed [SCALE_W-1:0] ENTRY_MAX =
    SCALE_W'((64'sd1 <<< (ENTRY_BITS - 1)) - 64'sd1);
  localparam logic signed [SCALE_W-1:0] ENTRY_MIN =
    SCALE_W'(-(64'sd1 <<< (ENTRY_BITS - 1)));

  typedef logic signed [SUM_W-1:0] sum_w_t;

  typedef struct packed {
    q30_t cysp, sysp, cycp, sysr, sycr, cpcr, cpsr, sycp, cysr, cycr, sp, cr, sr;
  } prod1_t;

  typedef struct packed {
    q30_t t01, t02, t21, t22, sysr, sycr, sp, cycp, cpcr, cpsr, sycp, cysr, cycr;
  } prod2_t;

  typedef struct packed {
    sum_w_t s00, s01, s02, s10, s11, s12, s20, s21, s22;
  } sums_t;

  // Q30 x Q30 rounded to Q30, ties away from zero
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [2*Q30_W-1:0] prod;
    logic signed [2*Q30_W-1:0] corr;
    logic signed [2*Q30_W-1:0] adj;
    prod    = (2*Q30_W)'(a) * (2*Q30_W)'(b);
    corr    = '0;
    corr[0] = prod[2*Q30_W-1];
    adj     = prod + (2*Q30_W)'(64'sd1 <<< (Q30_FRAC - 1)) - corr;
    return Q30_W'(adj >>> Q30_FRAC);
  endfunction

  function automatic logic signed [ENTRY_BITS-1:0] to_entry(input sum_w_t v);
    logic signed [SCALE_W-1:0] wide;
    logic signed [SCALE_W-1:0] corr;
    logic signed [SCALE_W-1:0] scaled;
    wide = SCALE_W'(v);
    corr = '0;
    if (OUT_SHIFT != 0) begin
      corr[0] = v[SUM_W-1];
    end
    if (ENTRY_BITS >= 32) begin
      scaled = wide <<< 1;
    end else begin
      scaled = (wide + ROUND_HALF - corr) >>> OUT_SHIFT;
    end
    if (scaled > ENTRY_MAX) begin
      scaled = ENTRY_MAX;
    end else if (scaled < ENTRY_MIN) begin
      scaled = ENTRY_MIN;
    end
    return ENTRY_BITS'(scaled);
  endfunction

  prod1_t  p1_d, p1_q;
  prod2_t  p2_d, p2_q;
  sums_t   sum_d, sum_q;
  matrix_t out_d, out_q;

  always_comb begin
    p1_d.cysp = qmul(trig_i.cy, trig_i.sp);
    p1_d.sysp = qmul(trig_i.sy, trig_i.sp);
    p1_d.cycp = qmul(trig_i.cy, trig_i.cp);
    p1_d.sysr = qmul(trig_i.sy, trig_i.sr);
    p1_d.sycr = qmul(trig_i.sy, trig_i.cr);
    p1_d.cpcr = qmul(trig_i.cp, trig_i.cr);
    p1_d.cpsr = qmul(trig_i.cp, trig_i.sr);
    p1_d.sycp = qmul(trig_i.sy, trig_i.cp);
    p1_d.cysr = qmul(trig_i.cy, trig_i.sr);
    p1_d.cycr = qmul(trig_i.cy, trig_i.cr);
    p1_d.sp   = trig_i.sp;
    p1_d.cr   = trig_i.cr;
    p1_d.sr   = trig_i.sr;
  end

  // Three-factor terms reuse the rounded pitch products
  always_comb begin
    p2_d.t01  = qmul(p1_q.cysp, p1_q.cr);
    p2_d.t02  = qmul(p1_q.cysp, p1_q.sr);
    p2_d.t21  = qmul(p1_q.sysp, p1_q.cr);
    p2_d.t22  = qmul(p1_q.sysp, p1_q.sr);
    p2_d.sysr = p1_q.sysr;
    p2_d.sycr = p1_q.sycr;
    p2_d.sp   = p1_q.sp;
    p2_d.cycp = p1_q.cycp;
    p2_d.cpcr = p1_q.cpcr;
    p2_d.cpsr = p1_q.cpsr;
    p2_d.sycp = p1_q.sycp;
    p2_d.cysr = p1_q.cysr;
    p2_d.cycr = p1_q.cycr;
  end

  always_comb begin
    sum_d.s00 = SUM_W'(p2_q.cycp);
    sum_d.s01 = SUM_W'(p2_q.sysr) - SUM_W'(p2_q.t01);
    sum_d.s02 = SUM_W'(p2_q.t02) + SUM_W'(p2_q.sycr);
    sum_d.s10 = SUM_W'(p2_q.sp);
    sum_d.s11 = SUM_W'(p2_q.cpcr);
    sum_d.s12 = -SUM_W'(p2_q.cpsr);
    sum_d.s20 = -SUM_W'(p2_q.sycp);
    sum_d.s21 = SUM_W'(p2_q.t21) + SUM_W'(p2_q.cysr);
    sum_d.s22 = SUM_W'(p2_q.cycr) - SUM_W'(p2_q.t22);
  end

  always_comb begin
    out_d.r00 = to_entry(sum_q.s00);
    out_d.r01 = to_entry(sum_q.s01);
    out_d.r02 = to_entry(sum_q.s02);
    out_d.r10 = to_entry(sum_q.s10);
    out_d.r11 = to_entry(sum_q.s11);
    out_d.r12 = to_entry(sum_q.s12);
    out_d.r20 = to_entry(sum_q.s20);
    out_d.r21 = to_entry(sum_q.s21);
    out_d.r22 = to_entry(sum_q.s22);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q <= p1_d;
    end
    if (en_i[1]) begin
      p2_q <= p2_d;
    end
    if (en_i[2]) begin
      sum_q <= sum_d;
    end
    if (en_i[3]) begin
      out_q <= out_d;
    end
  end

  assign matrix_o = out_q;

endmodule

`default_nettype wire

/* hdl/euler_to_rotation_matrix_unit.sv */
`default_nettype none
// Stages: 12 registered stages lie between request acceptance and result valid.
// Throughput: one request per cycle; each stage holds one item and moves it on
// whenever the next stage is free, so bubbles collapse under output stall.
// Depth: quadrant fold, square, five Horner cells, final product, four matrix stages.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.

module euler_to_rotation_matrix_unit import e2r_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  e2r_angle_if.sink    angles_i,
  e2r_matrix_if.source matrix_o
);

  localparam int LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  logic [TURN_W-1:0]     pitch_turn, yaw_turn, roll_turn;
  q30_t                  sp, cp, sy, cy, sr, cr;
  trig_t                 trig;
  matrix_t               matrix;

  // A stage loads when it is empty or its successor loads too
  always_comb begin
    en[LAST] = !v_q[LAST] || matrix_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= angles_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign pitch_turn = TURN_W'(unsigned'(angles_i.req.pitch_angle)) << TURN_SHIFT;
  assign yaw_turn   = TURN_W'(unsigned'(angles_i.req.yaw_angle)) << TURN_SHIFT;
  assign roll_turn  = TURN_W'(unsigned'(angles_i.req.roll_angle)) << TURN_SHIFT;

  e2r_sine_lane u_sp (
    .clk_i (clk_i), .en_i (en[LANE_STAGES-1:0]), .turn_i (pitch_turn), .sine_o (sp)
  );
  e2r_sine_lane u_cp (
    .clk_i (clk_i), .en_i (en[LANE_STAGES-1:0]), .turn_i (pitch_turn + COS_OFFSET),
    .sine_o (cp)
  );
  e2r_sine_lane u_sy (
    .clk_i (clk_i), .en_i (en[LANE_STAGES-1:0]), .turn_i (yaw_turn), .sine_o (sy)
  );
  e2r_sine_lane u_cy (
    .clk_i (clk_i), .en_i (en[LANE_STAGES-1:0]), .turn_i (yaw_turn + COS_OFFSET),
    .sine_o (cy)
  );
  e2r_sine_lane u_sr (
    .clk_i (clk_i), .en_i (en[LANE_STAGES-1:0]), .turn_i (roll_turn), .sine_o (sr)
  );
  e2r_sine_lane u_cr (
    .clk_i (clk_i), .en_i (en[LANE_STAGES-1:0]), .turn_i (roll_turn + COS_OFFSET),
    .sine_o (cr)
  );

  always_comb begin
    trig.sp = sp;
    trig.cp = cp;
    trig.sy = sy;
    trig.cy = cy;
    trig.sr = sr;
    trig.cr = cr;
  end

  e2r_matrix u_matrix (
    .clk_i    (clk_i),
    .en_i     (en[NUM_STAGES-1:LANE_STAGES]),
    .trig_i   (trig),
    .matrix_o (matrix)
  );

  assign angles_i.ready = en[0];
  assign matrix_o.valid = v_q[LAST];
  assign matrix_o.rsp   = matrix;

`ifndef SYNTH
  a_ready_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matrix_o.ready |-> angles_i.ready)
    else $error("input stalled while output side is ready");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> angles_i.ready)
    else $error("empty first stage refuses a request");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angles_i.valid && angles_i.ready |=> v_q[0])
    else $error("accepted request did not enter the pipeline");

  a_last_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[LAST] && v_q[LAST-1] |=> matrix_o.valid)
    else $error("item lost entering the output stage");
`endif

endmodule

`default_nettype wire
